@@ design/stb_pkg.sv @@
// Shared types and constants for the soft timer bank.
// Holds the request and response beat layouts, the timer entry layout and the
// request and sequencer state codes. Depends on nothing.
`default_nettype none

package stb_pkg;

    // Request codes carried in req_type.
    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_START_ONCE = 3'd1,
        REQ_START_AUTO = 3'd2,
        REQ_STOP       = 3'd3,
        REQ_CHECK      = 3'd4
    } req_code_t;

    // One request beat.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  timer_id;
        logic [31:0] period;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic expired;
        logic bad_id;
    } rsp_t;

    // One timer as it is kept in the state memory.
    typedef struct packed {
        logic [31:0] down_count;
        logic [31:0] reload_value;
        logic        expiry_flag;
        logic        auto_mode;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_ACC_RD,
        ST_WAIT,
        ST_FINISH
    } seq_state_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic        accept;
        logic        rd_en;
        logic [7:0]  rd_addr;
        logic [2:0]  req_type;
        logic [31:0] period;
        logic        bad_id;
        logic        rsp_load;
    } seq_ctl_t;

endpackage

`default_nettype wire

@@ design/soft_timer_bank.sv @@
// Soft timer bank
//
// Requests arrive on req (req_valid / req_stall), one beat per request, and
// each request gives exactly one response beat on rsp (rsp_valid / rsp_stall).
// A request is taken when req_valid is high and req_stall is low; the bank
// works on one request at a time and holds req_stall high while it does.
//
// All timer state lives in one memory with a registered read, one entry per
// timer. A tick reads, updates and writes back every entry in turn, one entry
// per cycle. Start, stop and check touch one entry; a request with a bad id or
// an unused code goes straight to the response. The next request is taken in
// the cycle after the response is loaded.
//
// The response sits in an output register. While the receiver stalls, the
// beat holds, and a finished request waits for the slot to free up.
// Reset clears the per-entry valid bits, so every timer reads as zero
// (stopped, flag clear, one-shot) right after reset with no clearing pass.
// Depends on stb_pkg, stb_ram and stb_seq.
`default_nettype none

module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int TIMERS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    seq_ctl_t         ctl;
    logic             rsp_free;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [TIMERS-1:0] entry_valid_reg;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t           cur;
    entry_t           upd;
    logic [31:0]      dec_count;
    logic             expired_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    stb_seq #(
        .TIMERS (TIMERS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .rsp_free  (rsp_free),
        .req_stall (req_stall),
        .ctl       (ctl)
    );

    stb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (rd_pend_reg),
        .wr_addr (rd_idx_reg),
        .wr_data (upd),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Track which entry the memory is returning this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ctl.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_idx_reg <= ctl.rd_addr[IDX_W-1:0];
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            entry_valid_reg[rd_idx_reg] <= 1'b1;
        end
    end

    assign cur       = entry_valid_reg[rd_idx_reg] ? entry_t'(ram_rd_data) : '0;
    assign dec_count = cur.down_count - 32'd1;

    // Modify the entry according to the request in progress.
    always_comb
    begin
        upd = cur;
        case (ctl.req_type)
            REQ_TICK:
            begin
                if (cur.down_count != 32'd0)
                begin
                    upd.down_count = dec_count;
                    if (dec_count == 32'd0)
                    begin
                        upd.expiry_flag = 1'b1;
                        if (cur.auto_mode)
                        begin
                            upd.down_count = cur.reload_value;
                        end
                    end
                end
            end
            REQ_START_ONCE, REQ_START_AUTO:
            begin
                upd.down_count   = ctl.period;
                upd.reload_value = ctl.period;
                upd.expiry_flag  = 1'b0;
                upd.auto_mode    = (ctl.req_type == REQ_START_AUTO);
            end
            REQ_STOP:
            begin
                upd.down_count  = 32'd0;
                upd.expiry_flag = 1'b0;
                upd.auto_mode   = 1'b0;
            end
            REQ_CHECK:
            begin
                upd.expiry_flag = 1'b0;
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    // Flag seen by a check.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            expired_reg <= 1'b0;
        end
        else if (rd_pend_reg && (ctl.req_type == REQ_CHECK))
        begin
            expired_reg <= cur.expiry_flag;
        end
    end

    // Response output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rsp_load)
        begin
            rsp_reg.expired <= expired_reg;
            rsp_reg.bad_id  <= ctl.bad_id;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ design/stb_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the timer state memory. Depends on nothing.
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/stb_seq.sv @@
// Request sequencer for the soft timer bank: accepts beats, walks the timer
// entries for a tick and times the response. Depends on stb_pkg.
`default_nettype none

module stb_seq
    import stb_pkg::*;
#(
    parameter int TIMERS = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire req_t     req,
    input  wire logic     rsp_free,
    output logic          req_stall,
    output seq_ctl_t      ctl
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);
    localparam logic [7:0] ID_LIMIT = 8'(TIMERS);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg;
    req_t             req_reg;
    logic             bad_reg;
    logic             accept;
    logic             is_addressed;
    logic             id_ok;

    // Classify the incoming request.
    always_comb
    begin
        is_addressed = (req.req_type == REQ_START_ONCE) || (req.req_type == REQ_START_AUTO) ||
                       (req.req_type == REQ_STOP) || (req.req_type == REQ_CHECK);
        id_ok        = req.timer_id < ID_LIMIT;
        accept       = req_valid && (state_reg == ST_IDLE);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type == REQ_TICK)
                    begin
                        state_next = ST_TICK_RD;
                    end
                    else if (is_addressed && id_ok)
                    begin
                        state_next = ST_ACC_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_TICK_RD:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_ACC_RD: state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_stall    = (state_reg != ST_IDLE);
        ctl.accept   = accept;
        ctl.rd_en    = (state_reg == ST_TICK_RD) || (state_reg == ST_ACC_RD);
        ctl.rd_addr  = (state_reg == ST_TICK_RD) ? 8'(cnt_reg) : req_reg.timer_id;
        ctl.req_type = req_reg.req_type;
        ctl.period   = req_reg.period;
        ctl.bad_id   = bad_reg;
        ctl.rsp_load = (state_reg == ST_FINISH) && rsp_free;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Entry counter for the tick walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= '0;
        end
        else if ((state_reg == ST_TICK_RD) && (cnt_reg != LAST_IDX))
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Captured request and its id check.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            bad_reg <= is_addressed && !id_ok;
        end
    end

endmodule

`default_nettype wire

@@ design/stb_checker.sv @@
// Port-level checks for the soft timer bank, bound to the top level.
// Depends on stb_pkg and soft_timer_bank.
`default_nettype none

module stb_checker
    import stb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // One request at a time: an accepted beat closes the input.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while the previous one was in progress");

    // A check with a bad id never reports an expiry.
    a_no_expired_with_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.expired && rsp.bad_id))
        else $error("response flags both expired and bad_id");

    // A new response only follows a cycle in which the bank was busy.
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without a request in progress");

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response beat changed");

endmodule

bind soft_timer_bank stb_checker u_stb_checker (.*);

`default_nettype wire
